>>> hdl/uri_cpu_pkg.sv
// Types, codes and lookup functions shared by the URI component parser.
package uri_cpu_pkg;

    localparam int ByteW   = 8;
    localparam int KindW   = 4;
    localparam int StatusW = 2;
    localparam int LenW    = 3;
    localparam int TdataOutW = 16;

    localparam logic [LenW-1:0] LenMax    = 3'd7;
    localparam logic [LenW-1:0] LenMailto = 3'd6;
    localparam logic [LenW-1:0] LenNews   = 3'd4;

    localparam logic [ByteW-1:0] ChColon = 8'h3a;
    localparam logic [ByteW-1:0] ChSlash = 8'h2f;
    localparam logic [ByteW-1:0] ChAt    = 8'h40;
    localparam logic [ByteW-1:0] ChPlus  = 8'h2b;
    localparam logic [ByteW-1:0] ChDot   = 8'h2e;
    localparam logic [ByteW-1:0] ChDash  = 8'h2d;
    localparam logic [ByteW-1:0] ChPrintLo = 8'h20;
    localparam logic [ByteW-1:0] ChPrintHi = 8'h7f;
    localparam logic [ByteW-1:0] CaseOffset = 8'h20;

    typedef enum logic [3:0] {
        PH_SCHEME = 4'd0,
        PH_SLASH1 = 4'd1,
        PH_SLASH2 = 4'd2,
        PH_HOST   = 4'd3,
        PH_PORT   = 4'd4,
        PH_PATH   = 4'd5,
        PH_MAILTO = 4'd6,
        PH_NEWS   = 4'd7,
        PH_ERROR  = 4'd8
    } phase_t;

    typedef enum logic [KindW-1:0] {
        K_DELIM  = 4'd0,
        K_SCHEME = 4'd1,
        K_HOST   = 4'd2,
        K_PORT   = 4'd3,
        K_PATH   = 4'd4,
        K_MISC   = 4'd5,
        K_CRED   = 4'd6,
        K_IGNORE = 4'd7,
        K_END    = 4'd8
    } kind_t;

    typedef enum logic [StatusW-1:0] {
        ST_RUNNING    = 2'd0,
        ST_OK         = 2'd1,
        ST_ERR_SCHEME = 2'd2,
        ST_ERR_FORMAT = 2'd3
    } status_t;

    typedef struct packed {
        phase_t          phase;
        logic [LenW-1:0] scheme_len;
        logic            mailto_match;
        logic            news_match;
        logic            cred_seen;
        status_t         err;
    } parse_state_t;

    localparam parse_state_t StateReset = '{
        phase:        PH_SCHEME,
        scheme_len:   '0,
        mailto_match: 1'b1,
        news_match:   1'b1,
        cred_seen:    1'b0,
        err:          ST_RUNNING
    };

    // Letter of "mailto" at a position below six.
    function automatic logic [ByteW-1:0] mailto_char(input logic [LenW-1:0] idx);
        logic [ByteW-1:0] c;
        case (idx)
            3'd0:    c = 8'h6d;
            3'd1:    c = 8'h61;
            3'd2:    c = 8'h69;
            3'd3:    c = 8'h6c;
            3'd4:    c = 8'h74;
            3'd5:    c = 8'h6f;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // Letter of "news" at a position below four.
    function automatic logic [ByteW-1:0] news_char(input logic [LenW-1:0] idx);
        logic [ByteW-1:0] c;
        case (idx)
            3'd0:    c = 8'h6e;
            3'd1:    c = 8'h65;
            3'd2:    c = 8'h77;
            3'd3:    c = 8'h73;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

>>> hdl/uri_cpu_step.sv
// Next-state and tagging logic for one URI byte.
module uri_cpu_step (
    input  logic [uri_cpu_pkg::ByteW-1:0] in_byte,
    input  uri_cpu_pkg::parse_state_t     cur,
    output uri_cpu_pkg::parse_state_t     nxt,
    output uri_cpu_pkg::kind_t            kind,
    output logic [uri_cpu_pkg::ByteW-1:0] out_byte,
    output uri_cpu_pkg::status_t          status
);
    import uri_cpu_pkg::*;

    logic is_lower;
    logic is_upper;
    logic is_scheme_ch;
    logic printable;
    logic [ByteW-1:0] lowered;

    assign is_lower  = (in_byte >= 8'h61) && (in_byte <= 8'h7a);
    assign is_upper  = (in_byte >= 8'h41) && (in_byte <= 8'h5a);
    assign is_scheme_ch = is_lower || is_upper || (in_byte == ChPlus) ||
                          (in_byte == ChDot) || (in_byte == ChDash);
    assign printable = (in_byte >= ChPrintLo) && (in_byte < ChPrintHi);
    assign lowered   = is_upper ? (in_byte + CaseOffset) : in_byte;

    always_comb begin
        nxt      = cur;
        kind     = K_IGNORE;
        out_byte = in_byte;
        status   = ST_RUNNING;

        if (in_byte == '0) begin
            // Terminator reports the final status and returns to reset.
            kind     = K_END;
            out_byte = '0;
            status   = (cur.err != ST_RUNNING) ? cur.err : ST_OK;
            nxt      = StateReset;
        end else begin
            unique case (cur.phase)
                PH_SCHEME: begin
                    if (in_byte == ChColon) begin
                        kind = K_DELIM;
                        if (cur.mailto_match && cur.scheme_len == LenMailto) begin
                            nxt.phase = PH_MAILTO;
                        end else if (cur.news_match && cur.scheme_len == LenNews) begin
                            nxt.phase = PH_NEWS;
                        end else begin
                            nxt.phase = PH_SLASH1;
                        end
                    end else if (is_scheme_ch) begin
                        kind     = K_SCHEME;
                        out_byte = lowered;
                        if (cur.scheme_len >= LenMailto ||
                            mailto_char(cur.scheme_len) != lowered) begin
                            nxt.mailto_match = 1'b0;
                        end
                        if (cur.scheme_len >= LenNews ||
                            news_char(cur.scheme_len) != lowered) begin
                            nxt.news_match = 1'b0;
                        end
                        if (cur.scheme_len != LenMax) begin
                            nxt.scheme_len = cur.scheme_len + 3'd1;
                        end
                    end else begin
                        nxt.err   = ST_ERR_SCHEME;
                        nxt.phase = PH_ERROR;
                    end
                end
                PH_SLASH1, PH_SLASH2: begin
                    if (in_byte == ChSlash) begin
                        kind      = K_DELIM;
                        nxt.phase = (cur.phase == PH_SLASH1) ? PH_SLASH2 : PH_HOST;
                    end else begin
                        nxt.err   = ST_ERR_FORMAT;
                        nxt.phase = PH_ERROR;
                    end
                end
                PH_HOST, PH_PORT: begin
                    if (in_byte == ChColon && cur.phase == PH_HOST) begin
                        kind      = K_DELIM;
                        nxt.phase = PH_PORT;
                    end else if (in_byte == ChSlash) begin
                        kind      = K_PATH;
                        nxt.phase = PH_PATH;
                    end else if (in_byte == ChAt) begin
                        // Only one credentials marker is allowed per string.
                        if (cur.cred_seen) begin
                            nxt.err   = ST_ERR_FORMAT;
                            nxt.phase = PH_ERROR;
                        end else begin
                            kind          = K_CRED;
                            nxt.cred_seen = 1'b1;
                            nxt.phase     = PH_HOST;
                        end
                    end else if (printable) begin
                        kind = (cur.phase == PH_HOST) ? K_HOST : K_PORT;
                    end else begin
                        nxt.err   = ST_ERR_FORMAT;
                        nxt.phase = PH_ERROR;
                    end
                end
                PH_PATH: begin
                    kind = K_PATH;
                end
                PH_MAILTO, PH_NEWS: begin
                    kind = K_MISC;
                end
                default: begin
                    kind = K_IGNORE;
                end
            endcase

            if (kind == K_IGNORE) begin
                status = nxt.err;
            end
        end
    end

endmodule

>>> hdl/uri_component_parser_unit.sv
// Top level of the URI component parser: input register, state and result register.
//
//  Channel | Dir | Ports                        | Contents
//  s_      | in  | s_tvalid s_tready s_tdata    | one URI byte per word
//  m_      | out | m_tvalid m_tready m_tdata    | tagged byte, status and kind per word
//                  m_tuser
//
// Every accepted word yields one result word, and a new word can be accepted
// on every cycle while the m_ side is not stalled. The parse state updates as a word
// moves from the input register into the result register, so consecutive bytes see
// it at once. aresetn is synchronous and active low; it empties both registers and
// returns the parser to the scheme phase. A stalled m_ side holds the result and the
// input register can still take one more word before s_tready drops.
module uri_component_parser_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] out_byte, [9:8] status, [15:10] zero
    output logic [3:0]  m_tuser    // [3:0] kind
);
    import uri_cpu_pkg::*;

    logic             in_valid_reg;
    logic             in_valid_next;
    logic [ByteW-1:0] in_byte_reg;
    parse_state_t     st_reg;
    parse_state_t     st_next;
    logic             m_valid_reg;
    logic             m_valid_next;
    kind_t            m_kind_reg;
    logic [ByteW-1:0] m_byte_reg;
    status_t          m_status_reg;

    parse_state_t     step_state;
    kind_t            step_kind;
    logic [ByteW-1:0] step_byte;
    status_t          step_status;
    logic             advance;
    logic             s_accept;

    uri_cpu_step u_step (
        .in_byte  (in_byte_reg),
        .cur      (st_reg),
        .nxt      (step_state),
        .kind     (step_kind),
        .out_byte (step_byte),
        .status   (step_status)
    );

    assign advance  = in_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_accept) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        m_valid_next = m_valid_reg;
        if (advance) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
        st_next = advance ? step_state : st_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            st_reg       <= StateReset;
        end else begin
            in_valid_reg <= in_valid_next;
            m_valid_reg  <= m_valid_next;
            st_reg       <= st_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_byte_reg <= s_tdata;
        end
        if (advance) begin
            m_kind_reg   <= step_kind;
            m_byte_reg   <= step_byte;
            m_status_reg <= step_status;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_kind_reg;
    assign m_tdata  = {{(TdataOutW - StatusW - ByteW){1'b0}}, m_status_reg, m_byte_reg};

    // An error code is held exactly while the parser sits in the error phase.
    a_err_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg.err != ST_RUNNING) == (st_reg.phase == PH_ERROR))
        else $error("error code and error phase disagree");

    // A terminator returns the parser to its reset state.
    a_term_reset: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && in_byte_reg == '0) |=> (st_reg == StateReset))
        else $error("terminator did not reset the parse state");

    // Only ignored and end words carry a nonzero status.
    a_status_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_status_reg != ST_RUNNING) |->
            (m_kind_reg == K_IGNORE || m_kind_reg == K_END))
        else $error("nonzero status on a tagged byte");

    // The end word always reports a final status.
    a_end_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_kind_reg == K_END) |-> (m_status_reg != ST_RUNNING))
        else $error("end word reports running status");

    // Once credentials were seen, the parser stays past the scheme until reset.
    a_cred_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        st_reg.cred_seen |-> (st_reg.phase == PH_HOST || st_reg.phase == PH_PORT ||
                              st_reg.phase == PH_PATH || st_reg.phase == PH_ERROR))
        else $error("credentials flag set in an unexpected phase");

endmodule
